@@ rtl/core/scbc_pkg.sv @@
package scbc_pkg;

  // Opcodes carried by each input word.
  localparam logic [1:0] OP_CLASSIFY = 2'd0;
  localparam logic [1:0] OP_CALIB    = 2'd1;
  localparam logic [1:0] OP_RESTART  = 2'd2;

  // Operations of the shared arithmetic unit.
  typedef logic [1:0] alu_op_t;
  localparam alu_op_t ALU_ADD     = 2'd0;
  localparam alu_op_t ALU_SUB     = 2'd1;
  localparam alu_op_t ALU_ABSDIFF = 2'd2;

  localparam int THRESH_BITS = 15;
  localparam int THRESH_MAX  = 32767;
  localparam int THRESH_GAIN = 20;
  localparam int REST_RESET  = 512;

endpackage

@@ rtl/core/scbc_alu.sv @@
module scbc_alu #(
  parameter int W = 14
) (
  input  scbc_pkg::alu_op_t op,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      y
);

  logic [W:0] diff;

  assign diff = {1'b0, a} - {1'b0, b};

  always_comb begin
    unique case (op)
      scbc_pkg::ALU_ADD:     y = a + b;
      scbc_pkg::ALU_SUB:     y = diff[W-1:0];
      scbc_pkg::ALU_ABSDIFF: y = diff[W] ? (b - a) : diff[W-1:0];
      default:               y = diff[W-1:0];
    endcase
  end

endmodule

@@ rtl/core/self_calibrating_bend_classifier.sv @@
// Self-calibrating bend classifier. Each input word carries an opcode and a
// converter sample. Classify and restart words, and calibration words that do
// not complete calibration, have their result word loaded into the output
// register at acceptance. The calibration word that fills the store starts a
// sequencer around one shared adder/subtractor: it sums the CALIB_SAMPLES
// stored entries, divides the sum by CALIB_SAMPLES with one multiplication
// by a fixed reciprocal, and, when the held threshold is zero, walks the
// store again for the peak deviation and scales it. A final state loads the
// result word; the block accepts no input word until then. A new input word
// is taken in the same cycle as the previous result word leaves the output
// register, so a stalled result channel also holds off the input. Writing
// the configuration register loads the held threshold at once; it should be
// written only while the block is idle.
module self_calibrating_bend_classifier #(
  parameter int CALIB_SAMPLES = 10,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_opcode,
  input  logic [SAMPLE_BITS-1:0]               in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [1:0]                    out_direction,
  output logic                                 out_calibrated,
  output logic [SAMPLE_BITS-1:0]               out_resting_level,
  output logic [scbc_pkg::THRESH_BITS-1:0]     out_active_threshold,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [scbc_pkg::THRESH_BITS-1:0]     cfg_data
);

  localparam int TB   = scbc_pkg::THRESH_BITS;
  localparam int AW   = SAMPLE_BITS + 4;                 // holds the full sum
  localparam int CNTW = $clog2(CALIB_SAMPLES + 1);
  localparam int IW   = (CALIB_SAMPLES > 1) ? $clog2(CALIB_SAMPLES) : 1;
  localparam int CW   = ((SAMPLE_BITS > TB) ? SAMPLE_BITS : TB) + 1;
  localparam int PW   = ((SAMPLE_BITS + 5) > TB) ? (SAMPLE_BITS + 5) : TB;
  // The rounded-up reciprocal gives the exact truncated quotient for any sum
  // that fits in AW bits.
  localparam int DL   = $clog2(CALIB_SAMPLES);
  localparam int DS   = AW + DL;
  localparam int MW   = AW + 2;
  localparam int QW   = AW + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((longint'(1) << DS) + longint'(CALIB_SAMPLES) - 1) / longint'(CALIB_SAMPLES));
  localparam logic [SAMPLE_BITS-1:0] REST_INIT = SAMPLE_BITS'(scbc_pkg::REST_RESET);
  localparam logic [IW-1:0] LAST_IDX = IW'(CALIB_SAMPLES - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_DEV  = 3'd3;
  localparam logic [2:0] ST_THR  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic [AW-1:0]          acc_r, acc_nxt;
  logic [SAMPLE_BITS-1:0] mean_r, mean_nxt;
  logic [SAMPLE_BITS-1:0] peak_r, peak_nxt;
  logic [CNTW-1:0]        count_r, count_nxt;
  logic                   cal_r, cal_nxt;
  logic [SAMPLE_BITS-1:0] rest_r, rest_nxt;
  logic [TB-1:0]          held_r, held_nxt;
  logic                   ovalid_r, ovalid_nxt;
  logic signed [1:0]      dir_r, dir_nxt;
  logic                   ocal_r, ocal_nxt;
  logic [SAMPLE_BITS-1:0] orest_r, orest_nxt;
  logic [TB-1:0]          othr_r, othr_nxt;

  // The store is read at the sequencer's single index only.
  logic [SAMPLE_BITS-1:0] store_r [CALIB_SAMPLES];

  scbc_pkg::alu_op_t      alu_op;
  logic [AW-1:0]          alu_a, alu_b, alu_y;
  logic [QW-1:0]          prod;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   accept;
  logic                   store_we;
  logic [CW-1:0]          sample_x, rest_x, held_x;
  logic [PW-1:0]          scaled;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE) && (!ovalid_r || out_ready);
  assign cfg_ready = 1'b1;
  assign rd_data   = store_r[idx_r];
  assign prod      = QW'(acc_r) * QW'(RECIP);
  assign sample_x  = CW'(in_sample);
  assign rest_x    = CW'(rest_r);
  assign held_x    = CW'(held_r);
  assign scaled    = PW'(peak_r) * PW'(scbc_pkg::THRESH_GAIN);
  assign store_we  = accept && (in_opcode == scbc_pkg::OP_CALIB) && !cal_r;

  // Operand selection for the shared unit: summing, then absolute deviation
  // from the mean.
  always_comb begin
    unique case (state_r)
      ST_SUM: begin
        alu_op = scbc_pkg::ALU_ADD;
        alu_a  = acc_r;
        alu_b  = AW'(rd_data);
      end
      ST_DEV: begin
        alu_op = scbc_pkg::ALU_ABSDIFF;
        alu_a  = AW'(rd_data);
        alu_b  = AW'(mean_r);
      end
      default: begin
        alu_op = scbc_pkg::ALU_ADD;
        alu_a  = acc_r;
        alu_b  = '0;
      end
    endcase
  end

  scbc_alu #(.W(AW)) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .y   (alu_y)
  );

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    acc_nxt    = acc_r;
    mean_nxt   = mean_r;
    peak_nxt   = peak_r;
    count_nxt  = count_r;
    cal_nxt    = cal_r;
    rest_nxt   = rest_r;
    held_nxt   = held_r;
    ovalid_nxt = ovalid_r && !out_ready;
    dir_nxt    = dir_r;
    ocal_nxt   = ocal_r;
    orest_nxt  = orest_r;
    othr_nxt   = othr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Default result word: state as it stands after this word.
          ovalid_nxt = 1'b1;
          dir_nxt    = 2'sd0;
          ocal_nxt   = cal_r;
          orest_nxt  = rest_r;
          othr_nxt   = held_r;
          case (in_opcode)
            scbc_pkg::OP_CLASSIFY: begin
              if (cal_r) begin
                if (sample_x > rest_x + held_x) begin
                  dir_nxt = 2'sd1;
                end else if (sample_x + held_x < rest_x) begin
                  dir_nxt = -2'sd1;
                end
              end
            end
            scbc_pkg::OP_CALIB: begin
              if (!cal_r) begin
                if (count_r == CNTW'(CALIB_SAMPLES - 1)) begin
                  // Store is full: hold the result until the sequence ends.
                  ovalid_nxt = 1'b0;
                  state_nxt  = ST_SUM;
                  idx_nxt    = '0;
                  acc_nxt    = '0;
                end else begin
                  count_nxt = count_r + CNTW'(1);
                end
              end
            end
            scbc_pkg::OP_RESTART: begin
              cal_nxt   = 1'b0;
              count_nxt = '0;
              ocal_nxt  = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SUM: begin
        acc_nxt = alu_y;
        idx_nxt = idx_r + IW'(1);
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DIV;
          idx_nxt   = '0;
        end
      end
      ST_DIV: begin
        // Truncated mean: the sum times the reciprocal, scaled back down.
        mean_nxt = prod[DS +: SAMPLE_BITS];
        peak_nxt = '0;
        idx_nxt  = '0;
        if (held_r == '0) begin
          state_nxt = ST_DEV;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_DEV: begin
        if (alu_y[SAMPLE_BITS-1:0] > peak_r) begin
          peak_nxt = alu_y[SAMPLE_BITS-1:0];
        end
        idx_nxt = idx_r + IW'(1);
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_THR;
          idx_nxt   = '0;
        end
      end
      ST_THR: begin
        if (scaled > PW'(scbc_pkg::THRESH_MAX)) begin
          held_nxt = TB'(scbc_pkg::THRESH_MAX);
        end else begin
          held_nxt = scaled[TB-1:0];
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        rest_nxt   = mean_r;
        cal_nxt    = 1'b1;
        count_nxt  = '0;
        ovalid_nxt = 1'b1;
        dir_nxt    = 2'sd0;
        ocal_nxt   = 1'b1;
        orest_nxt  = mean_r;
        othr_nxt   = held_r;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // The configuration write loads the threshold and wins over a derived value.
    if (cfg_valid && cfg_ready) begin
      held_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      cal_r    <= 1'b0;
      rest_r   <= REST_INIT;
      held_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cal_r    <= cal_nxt;
      rest_r   <= rest_nxt;
      held_r   <= held_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    acc_r   <= acc_nxt;
    mean_r  <= mean_nxt;
    peak_r  <= peak_nxt;
    dir_r   <= dir_nxt;
    ocal_r  <= ocal_nxt;
    orest_r <= orest_nxt;
    othr_r  <= othr_nxt;
    if (store_we) begin
      store_r[count_r[IW-1:0]] <= in_sample;
    end
  end

  assign out_valid            = ovalid_r;
  assign out_direction        = dir_r;
  assign out_calibrated       = ocal_r;
  assign out_resting_level    = orest_r;
  assign out_active_threshold = othr_r;

endmodule

@@ tb/sv/tb_self_calibrating_bend_classifier.sv @@
`timescale 1ns / 100ps

// Testbench for the self-calibrating bend classifier. Input words are pushed
// through the valid/ready input channel with random gaps, result words are
// drained with random back-pressure, and every result word is checked field by
// field against an in-bench model of the classifier that is updated at the
// moment each input word is accepted.
module tb_self_calibrating_bend_classifier;

  localparam int SAMPLE_W      = 10;
  localparam int STORE_DEPTH   = 10;
  localparam int SAMPLE_TOP    = (1 << SAMPLE_W) - 1;
  localparam int TW            = scbc_pkg::THRESH_BITS;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // The slowest legal run (full calibration sequences, long gaps and long
  // stalls on every word) stays well below this limit.
  localparam int CYCLE_LIMIT   = 1_500_000;
  // Longest internal sequence of the block, plus some margin.
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic signed [1:0]   direction;
    logic                calibrated;
    logic [SAMPLE_W-1:0] resting_level;
    logic [TW-1:0]       active_threshold;
  } bend_result_t;

  // Every input starts at a known value before the first edge.
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_opcode = scbc_pkg::OP_CLASSIFY;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [1:0]   out_direction;
  logic                out_calibrated;
  logic [SAMPLE_W-1:0] out_resting_level;
  logic [TW-1:0]       out_active_threshold;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TW-1:0]       cfg_data = '0;

  // Model state of the classifier.
  logic [SAMPLE_W-1:0] cal_store [STORE_DEPTH];
  logic [3:0]          cal_count;
  logic                cal_done;
  logic [SAMPLE_W-1:0] rest_level;
  logic [TW-1:0]       window_half;

  bend_result_t expected_classifications [$];

  int  mismatches = 0;
  int  cycle_count = 0;
  int  rx_stall_left = 0;
  // When set, the corresponding side runs flat out with no random idling.
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;

  self_calibrating_bend_classifier u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_opcode            (in_opcode),
    .in_sample            (in_sample),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_direction        (out_direction),
    .out_calibrated       (out_calibrated),
    .out_resting_level    (out_resting_level),
    .out_active_threshold (out_active_threshold),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Run-away guard: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Back-pressure on the result channel. Most cycles are ready; the others
  // start a stall, and a few of the stalls run for a long stretch, so that
  // a held result word also holds off the input.
  always @(posedge clk) begin : drive_out_ready
    int pick;
    if (rx_stall_left > 0) begin
      out_ready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_calm) begin
      out_ready <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        rx_stall_left <= (pick < 95) ? $urandom_range(0, 2) : $urandom_range(9, 59);
      end
    end
  end

  // Result checker. A result word accepted at this edge belongs to an input
  // word accepted at an earlier edge, so its expectation is already queued.
  always @(posedge clk) begin : check_results
    bend_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_classifications.size() == 0) begin
        $error("result word arrived with no expectation pending");
        mismatches++;
      end else begin
        want = expected_classifications.pop_front();
        if (out_direction !== want.direction) begin
          $error("direction: expected %0d, got %0d", want.direction, out_direction);
          mismatches++;
        end
        if (out_calibrated !== want.calibrated) begin
          $error("calibrated: expected %0d, got %0d", want.calibrated, out_calibrated);
          mismatches++;
        end
        if (out_resting_level !== want.resting_level) begin
          $error("resting_level: expected %0d, got %0d",
                 want.resting_level, out_resting_level);
          mismatches++;
        end
        if (out_active_threshold !== want.active_threshold) begin
          $error("active_threshold: expected %0d, got %0d",
                 want.active_threshold, out_active_threshold);
          mismatches++;
        end
      end
    end
  end

  task automatic reset_classifier_model();
    foreach (cal_store[i]) cal_store[i] = '0;
    cal_count   = '0;
    cal_done    = 1'b0;
    rest_level  = SAMPLE_W'(scbc_pkg::REST_RESET);
    window_half = '0;
  endtask

  // Advances the model by one accepted input word and queues the result word
  // that the block must produce for it.
  task automatic predict_classification(input logic [1:0] op,
                                        input logic [SAMPLE_W-1:0] s);
    bend_result_t res;
    int total;
    int mean;
    int peak;
    int dev;
    int scaled;
    res.direction = 2'sd0;
    case (op)
      scbc_pkg::OP_CLASSIFY: begin
        if (cal_done) begin
          if (int'(s) > int'(rest_level) + int'(window_half))
            res.direction = 2'sd1;
          else if (int'(s) < int'(rest_level) - int'(window_half))
            res.direction = -2'sd1;
        end
      end
      scbc_pkg::OP_CALIB: begin
        // Calibration words are ignored once calibration has completed.
        if (!cal_done) begin
          cal_store[cal_count] = s;
          cal_count = cal_count + 4'd1;
          if (cal_count >= STORE_DEPTH) begin
            total = 0;
            foreach (cal_store[i]) total += int'(cal_store[i]);
            mean = total / STORE_DEPTH;
            rest_level = mean[SAMPLE_W-1:0];
            // Only a zero threshold is derived; a preset one is kept.
            if (window_half == '0) begin
              peak = 0;
              foreach (cal_store[i]) begin
                dev = int'(cal_store[i]) - mean;
                if (dev < 0) dev = -dev;
                if (dev > peak) peak = dev;
              end
              scaled = peak * scbc_pkg::THRESH_GAIN;
              window_half = (scaled > scbc_pkg::THRESH_MAX) ? TW'(scbc_pkg::THRESH_MAX)
                                                            : TW'(scaled);
            end
            cal_done  = 1'b1;
            cal_count = '0;
          end
        end
      end
      scbc_pkg::OP_RESTART: begin
        cal_done  = 1'b0;
        cal_count = '0;
      end
      default: begin
        // The unused opcode changes nothing.
      end
    endcase
    res.calibrated       = cal_done;
    res.resting_level    = rest_level;
    res.active_threshold = window_half;
    expected_classifications.push_back(res);
  endtask

  function automatic int pick_gap();
    int pick;
    if (tx_calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 75) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    return SAMPLE_W'($urandom_range(0, SAMPLE_TOP));
  endfunction

  function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
    if (v < 0) return '0;
    if (v > SAMPLE_TOP) return SAMPLE_W'(SAMPLE_TOP);
    return SAMPLE_W'(v);
  endfunction

  // Sends one input word. A gap, if any, lowers valid first; with no gap the
  // new word follows the previous one on the very next edge, so valid is not
  // touched twice in one step.
  task automatic send_word(input logic [1:0] op, input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    predict_classification(op, s);
  endtask

  // Parks the input channel and waits until every queued result word has come
  // back. At least one edge passes, so a following word may raise valid again.
  task automatic settle_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_classifications.size() != 0);
  endtask

  // The threshold register is only written with the block idle. Every input
  // word yields a result word, so an empty queue means the block is idle.
  task automatic write_threshold(input logic [TW-1:0] value);
    settle_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    window_half = value;
    cfg_valid <= 1'b0;
  endtask

  // Straight after reset: nothing is calibrated, so classify words give zero
  // at both ends of the sample range, and the unused opcode is ignored.
  task automatic test_uncalibrated();
    send_word(scbc_pkg::OP_CLASSIFY, '0);
    send_word(scbc_pkg::OP_CLASSIFY, SAMPLE_W'(SAMPLE_TOP));
    send_word(OP_UNUSED, SAMPLE_W'(SAMPLE_TOP));
  endtask

  // Calibration from the two extremes of the range with a derived threshold,
  // then a calibration word after completion, which must be ignored.
  task automatic test_extreme_calibration();
    write_threshold('0);
    for (int k = 0; k < STORE_DEPTH; k++)
      send_word(scbc_pkg::OP_CALIB, (k % 2 == 0) ? '0 : SAMPLE_W'(SAMPLE_TOP));
    send_word(scbc_pkg::OP_CLASSIFY, '0);
    send_word(scbc_pkg::OP_CLASSIFY, SAMPLE_W'(SAMPLE_TOP));
    send_word(scbc_pkg::OP_CALIB, SAMPLE_W'(SAMPLE_TOP));
    send_word(OP_UNUSED, '0);
  endtask

  // A preset threshold survives calibration; the window edges are probed
  // exactly on the edge and one count outside on each side.
  task automatic test_preset_window();
    write_threshold(TW'(5));
    send_word(scbc_pkg::OP_RESTART, '0);
    for (int k = 0; k < STORE_DEPTH; k++)
      send_word(scbc_pkg::OP_CALIB, SAMPLE_W'(100));
    send_word(scbc_pkg::OP_CLASSIFY, SAMPLE_W'(105));
    send_word(scbc_pkg::OP_CLASSIFY, SAMPLE_W'(106));
    send_word(scbc_pkg::OP_CLASSIFY, SAMPLE_W'(95));
    send_word(scbc_pkg::OP_CLASSIFY, SAMPLE_W'(94));
  endtask

  // Restart in the middle of a calibration drops the partial fill but keeps
  // the threshold and the resting level.
  task automatic test_restart_keeps_threshold();
    send_word(scbc_pkg::OP_RESTART, '0);
    send_word(scbc_pkg::OP_CALIB, SAMPLE_W'(700));
    send_word(scbc_pkg::OP_CALIB, SAMPLE_W'(3));
    send_word(scbc_pkg::OP_RESTART, SAMPLE_W'(SAMPLE_TOP));
    send_word(scbc_pkg::OP_CLASSIFY, SAMPLE_W'(100));
  endtask

  // Classify samples aimed at the current window edges, at the resting level,
  // or anywhere in the range.
  function automatic logic [SAMPLE_W-1:0] window_probe();
    int delta;
    delta = int'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 3))
      0: return clamp_sample(int'(rest_level) + int'(window_half) + delta);
      1: return clamp_sample(int'(rest_level) - int'(window_half) + delta);
      2: return clamp_sample(int'(rest_level) + delta);
      default: return random_sample();
    endcase
  endfunction

  // Mostly whole calibration sequences with random content, each followed by
  // a run of classify words; a few sequences are cut short by a restart, and
  // the rest of the traffic is words with random opcodes.
  task automatic run_random_traffic(input int words);
    int sent;
    int centre;
    int spread;
    int abort_at;
    int run_len;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(0, 99) < 70) begin
        send_word(scbc_pkg::OP_RESTART, random_sample());
        abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, STORE_DEPTH - 1)
                                               : STORE_DEPTH;
        centre = $urandom_range(0, SAMPLE_TOP);
        case ($urandom_range(0, 3))
          0: spread = 0;
          1: spread = 2;
          2: spread = 40;
          default: spread = SAMPLE_TOP;
        endcase
        for (int k = 0; k < STORE_DEPTH; k++) begin
          if (k == abort_at) begin
            send_word(scbc_pkg::OP_RESTART, random_sample());
            break;
          end
          send_word(scbc_pkg::OP_CALIB,
                    clamp_sample(centre + int'($urandom_range(0, 2 * spread)) - spread));
        end
        run_len = $urandom_range(4, 24);
        for (int k = 0; k < run_len; k++)
          send_word(scbc_pkg::OP_CLASSIFY, window_probe());
        sent += STORE_DEPTH + 1 + run_len;
      end else begin
        send_word(2'($urandom_range(0, 3)), random_sample());
        sent++;
      end
    end
  endtask

  // Random phases under several threshold settings, the extremes among them.
  // Each register write waits for the block to drain first.
  task automatic test_random_phases();
    logic [TW-1:0] setting;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0, 4, 6: setting = '0;
        1:       setting = TW'(scbc_pkg::THRESH_MAX);
        2:       setting = TW'(1);
        3:       setting = TW'($urandom_range(2, 200));
        5:       setting = TW'($urandom_range(0, scbc_pkg::THRESH_MAX));
        default: setting = TW'(30);
      endcase
      write_threshold(setting);
      tx_calm = (ph == 2);
      rx_calm = (ph == 5);
      run_random_traffic(225);
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    reset_classifier_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_uncalibrated();
    test_extreme_calibration();
    test_preset_window();
    test_restart_keeps_threshold();
    test_random_phases();

    settle_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_classifications.size() != 0) begin
      $error("%0d result words never arrived", expected_classifications.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ self_calibrating_bend_classifier.f @@
rtl/core/scbc_pkg.sv
rtl/core/scbc_alu.sv
rtl/core/self_calibrating_bend_classifier.sv
tb/sv/tb_self_calibrating_bend_classifier.sv
